[src/cpq_pkg.sv]
// Package for the category priority queue: sizes, codes, reset values and
// the sequencer state type. Used by the channel interfaces, the RAM and the top.
package cpq_pkg;

   localparam int DEPTH_DEF     = 8;
   localparam int TAG_WIDTH_DEF = 16;
   localparam int PRIO_W        = 16;
   localparam int OUT_TAG_W     = 16;
   localparam int NUM_CAT       = 5;
   localparam int CAT_W         = 3;
   localparam int ACT_W         = 2;
   localparam int STAT_W        = 2;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int FILL_W_DEF    = $clog2(DEPTH_DEF + 1);

   localparam logic signed [PRIO_W-1:0] MIN_PRIO = 16'sh8000;

   localparam logic signed [PRIO_W-1:0] BASE_RESET [NUM_CAT] =
      '{16'sd50, 16'sd40, 16'sd30, 16'sd20, 16'sd10};

   typedef enum logic [ACT_W-1:0] {
      ACT_ENQ_CAT  = 2'd0,
      ACT_ENQ_PRIO = 2'd1,
      ACT_DEQ      = 2'd2,
      ACT_NOP      = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_EMPTY   = 2'd2,
      STAT_BAD_CAT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_INS_START,
      S_INS_WALK,
      S_DEQ_HEAD,
      S_DEQ_WALK,
      S_HEAD_RD,
      S_HEAD
   } state_type;

endpackage

[src/cpq_req_if.sv]
// Request channel of the category priority queue: valid, ready and one word.
// Depends on cpq_pkg for field widths.
interface cpq_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [cpq_pkg::ACT_W-1:0]                action;
   logic [cpq_pkg::CAT_W-1:0]                category;
   logic signed [cpq_pkg::PRIO_W-1:0]        explicit_priority;
   logic [cpq_pkg::OUT_TAG_W-1:0]            payload_tag;

   modport source (output valid, output action, output category,
                   output explicit_priority, output payload_tag, input ready);
   modport sink   (input valid, input action, input category,
                   input explicit_priority, input payload_tag, output ready);
endinterface

[src/cpq_rsp_if.sv]
// Response channel of the category priority queue: valid, ready and one word.
// Depends on cpq_pkg for field widths; FILL_W follows the queue depth.
interface cpq_rsp_if #(parameter int FILL_W = cpq_pkg::FILL_W_DEF);
   logic                                     valid;
   logic                                     ready;
   logic [cpq_pkg::STAT_W-1:0]               status;
   logic [cpq_pkg::OUT_TAG_W-1:0]            removed_tag;
   logic signed [cpq_pkg::PRIO_W-1:0]        removed_priority;
   logic                                     head_valid;
   logic [cpq_pkg::OUT_TAG_W-1:0]            head_tag;
   logic signed [cpq_pkg::PRIO_W-1:0]        head_priority;
   logic [FILL_W-1:0]                        fill_count;

   modport source (output valid, output status, output removed_tag,
                   output removed_priority, output head_valid, output head_tag,
                   output head_priority, output fill_count, input ready);
   modport sink   (input valid, input status, input removed_tag,
                   input removed_priority, input head_valid, input head_tag,
                   input head_priority, input fill_count, output ready);
endinterface

[src/cpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on cpq_pkg for default sizes.
module cpq_ram #(
   parameter int WIDTH = cpq_pkg::PRIO_W + cpq_pkg::TAG_WIDTH_DEF,
   parameter int DEPTH = cpq_pkg::DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

[src/category_priority_queue.sv]
// Category priority queue: a sorted queue of DEPTH entries held in one RAM.
// Entries are ordered by non-increasing priority, head at address 0.
// Requests arrive on req_ch and each gives exactly one word on rsp_ch.
// Action 0 enqueues with the running counter of the given category, which
// then decrements and saturates at the most negative value. Action 1
// enqueues with an explicit priority, action 2 removes the head.
// The response reports the status, the removed entry, the new head and fill.
// One sequencer steps through the RAM one entry per cycle. After acceptance an
// item passes the execute state, then the insert states (start, walk) or the
// dequeue states (head, walk) when an entry is stored or removed, and then the
// head read and head states, which load the response word.
// req_ch.ready is high only while the sequencer is idle, so the next request
// can be taken at the edge after the response word is loaded. A finished
// response waits in an output register, so the next request may be taken
// while the receiver stalls; the sequencer then holds its last step until
// that register is free.
// Reset is synchronous; it empties the queue, drops any pending response and
// loads each category counter with its default base value. No clearing pass
// is needed. A write on the csr_ port loads a category counter directly.
module category_priority_queue #(
   parameter int DEPTH     = cpq_pkg::DEPTH_DEF,
   parameter int TAG_WIDTH = cpq_pkg::TAG_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   cpq_req_if.sink                           req_ch,
   cpq_rsp_if.source                         rsp_ch,
   input  logic                              csr_write_enable,
   input  logic [cpq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpq_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int PRIO_W = cpq_pkg::PRIO_W;
   localparam int MEM_W  = PRIO_W + TAG_WIDTH;
   localparam int OUT_W  = cpq_pkg::OUT_TAG_W;
   localparam int EXT_W  = (TAG_WIDTH > OUT_W) ? TAG_WIDTH : OUT_W;

   cpq_pkg::state_type               state_ff, state_in;
   cpq_pkg::action_type              action_ff, action_in;
   logic [cpq_pkg::CAT_W-1:0]        cat_ff, cat_in;
   logic signed [PRIO_W-1:0]         eprio_ff, eprio_in;
   logic [TAG_WIDTH-1:0]             tag_ff, tag_in;
   logic signed [PRIO_W-1:0]         prio_ff, prio_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [CNT_W-1:0]                 occ_ff, occ_in;
   cpq_pkg::status_type              status_ff, status_in;
   logic [TAG_WIDTH-1:0]             rtag_ff, rtag_in;
   logic signed [PRIO_W-1:0]         rprio_ff, rprio_in;
   logic signed [PRIO_W-1:0]         counter_ff [cpq_pkg::NUM_CAT];
   logic signed [PRIO_W-1:0]         counter_in [cpq_pkg::NUM_CAT];

   logic                             rsp_valid_ff, rsp_valid_in;
   cpq_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [OUT_W-1:0]                 rsp_rtag_ff, rsp_rtag_in;
   logic signed [PRIO_W-1:0]         rsp_rprio_ff, rsp_rprio_in;
   logic                             rsp_hvalid_ff, rsp_hvalid_in;
   logic [OUT_W-1:0]                 rsp_htag_ff, rsp_htag_in;
   logic signed [PRIO_W-1:0]         rsp_hprio_ff, rsp_hprio_in;
   logic [CNT_W-1:0]                 rsp_fill_ff, rsp_fill_in;

   logic                             wr_en;
   logic [IDX_W-1:0]                 wr_addr;
   logic [MEM_W-1:0]                 wr_data;
   logic [IDX_W-1:0]                 rd_addr;
   logic [MEM_W-1:0]                 rd_data;
   logic signed [PRIO_W-1:0]         rd_prio;
   logic [TAG_WIDTH-1:0]             rd_tag;
   logic [MEM_W-1:0]                 new_word;
   logic                             full;
   logic                             empty;
   logic                             shift_down;
   logic                             deq_more;
   logic                             rsp_load;
   logic [EXT_W-1:0]                 req_tag_ext;
   logic [EXT_W-1:0]                 rtag_ext;
   logic [EXT_W-1:0]                 htag_ext;

   cpq_ram #(
      .WIDTH (MEM_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   assign rd_prio     = rd_data[MEM_W-1 -: PRIO_W];
   assign rd_tag      = rd_data[TAG_WIDTH-1:0];
   assign new_word    = {prio_ff, tag_ff};
   assign full        = (occ_ff == CNT_W'(DEPTH));
   assign empty       = (occ_ff == '0);
   assign shift_down  = (rd_prio <= prio_ff);
   assign deq_more    = ((CNT_W+1)'(idx_ff) + (CNT_W+1)'(2)) < (CNT_W+1)'(occ_ff);
   assign rsp_load    = !rsp_valid_ff || rsp_ch.ready;
   assign req_tag_ext = EXT_W'(req_ch.payload_tag);
   assign rtag_ext    = EXT_W'(rtag_ff);
   assign htag_ext    = EXT_W'(rd_tag);

   assign req_ch.ready = (state_ff == cpq_pkg::S_IDLE);

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.removed_tag      = rsp_rtag_ff;
   assign rsp_ch.removed_priority = rsp_rprio_ff;
   assign rsp_ch.head_valid       = rsp_hvalid_ff;
   assign rsp_ch.head_tag         = rsp_htag_ff;
   assign rsp_ch.head_priority    = rsp_hprio_ff;
   assign rsp_ch.fill_count       = rsp_fill_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cpq_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               state_in = cpq_pkg::S_EXEC;
            end
         end
         cpq_pkg::S_EXEC: begin
            unique case (action_ff)
               cpq_pkg::ACT_ENQ_CAT: begin
                  if (cat_ff >= cpq_pkg::CAT_W'(cpq_pkg::NUM_CAT) || full) begin
                     state_in = cpq_pkg::S_HEAD_RD;
                  end else begin
                     state_in = cpq_pkg::S_INS_START;
                  end
               end
               cpq_pkg::ACT_ENQ_PRIO: begin
                  state_in = full ? cpq_pkg::S_HEAD_RD : cpq_pkg::S_INS_START;
               end
               cpq_pkg::ACT_DEQ: begin
                  state_in = empty ? cpq_pkg::S_HEAD_RD : cpq_pkg::S_DEQ_HEAD;
               end
               default: begin
                  state_in = cpq_pkg::S_HEAD_RD;
               end
            endcase
         end
         cpq_pkg::S_INS_START: begin
            state_in = (idx_ff == '0) ? cpq_pkg::S_HEAD_RD : cpq_pkg::S_INS_WALK;
         end
         cpq_pkg::S_INS_WALK: begin
            if (!shift_down) begin
               state_in = cpq_pkg::S_HEAD_RD;
            end else if (idx_ff == IDX_W'(1)) begin
               state_in = cpq_pkg::S_INS_START;
            end
         end
         cpq_pkg::S_DEQ_HEAD: begin
            if (occ_ff == CNT_W'(1)) begin
               state_in = cpq_pkg::S_HEAD_RD;
            end else begin
               state_in = cpq_pkg::S_DEQ_WALK;
            end
         end
         cpq_pkg::S_DEQ_WALK: begin
            if (!deq_more) begin
               state_in = cpq_pkg::S_HEAD_RD;
            end
         end
         cpq_pkg::S_HEAD_RD: begin
            state_in = cpq_pkg::S_HEAD;
         end
         cpq_pkg::S_HEAD: begin
            if (rsp_load) begin
               state_in = cpq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cpq_pkg::S_IDLE;
         end
      endcase
   end

   // RAM control.
   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = new_word;
      unique case (state_ff)
         cpq_pkg::S_INS_START: begin
            if (idx_ff == '0) begin
               wr_en = 1'b1;
            end else begin
               rd_addr = idx_ff - IDX_W'(1);
            end
         end
         cpq_pkg::S_INS_WALK: begin
            wr_en = 1'b1;
            if (shift_down) begin
               wr_data = rd_data;
               rd_addr = idx_ff - IDX_W'(2);
            end
         end
         cpq_pkg::S_DEQ_HEAD: begin
            rd_addr = IDX_W'(1);
         end
         cpq_pkg::S_DEQ_WALK: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            rd_addr = idx_ff + IDX_W'(2);
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      action_in     = action_ff;
      cat_in        = cat_ff;
      eprio_in      = eprio_ff;
      tag_in        = tag_ff;
      prio_in       = prio_ff;
      idx_in        = idx_ff;
      occ_in        = occ_ff;
      status_in     = status_ff;
      rtag_in       = rtag_ff;
      rprio_in      = rprio_ff;
      counter_in    = counter_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rtag_in   = rsp_rtag_ff;
      rsp_rprio_in  = rsp_rprio_ff;
      rsp_hvalid_in = rsp_hvalid_ff;
      rsp_htag_in   = rsp_htag_ff;
      rsp_hprio_in  = rsp_hprio_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         cpq_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               action_in = cpq_pkg::action_type'(req_ch.action);
               cat_in    = req_ch.category;
               eprio_in  = req_ch.explicit_priority;
               tag_in    = req_tag_ext[TAG_WIDTH-1:0];
               status_in = cpq_pkg::STAT_OK;
               rtag_in   = '0;
               rprio_in  = '0;
            end
         end
         cpq_pkg::S_EXEC: begin
            idx_in = occ_ff[IDX_W-1:0];
            unique case (action_ff)
               cpq_pkg::ACT_ENQ_CAT: begin
                  if (cat_ff < cpq_pkg::CAT_W'(cpq_pkg::NUM_CAT)) begin
                     prio_in = counter_ff[cat_ff];
                     if (counter_ff[cat_ff] != cpq_pkg::MIN_PRIO) begin
                        counter_in[cat_ff] = counter_ff[cat_ff] - PRIO_W'(1);
                     end
                     if (full) begin
                        status_in = cpq_pkg::STAT_FULL;
                     end
                  end else begin
                     status_in = cpq_pkg::STAT_BAD_CAT;
                  end
               end
               cpq_pkg::ACT_ENQ_PRIO: begin
                  prio_in = eprio_ff;
                  if (full) begin
                     status_in = cpq_pkg::STAT_FULL;
                  end
               end
               cpq_pkg::ACT_DEQ: begin
                  if (empty) begin
                     status_in = cpq_pkg::STAT_EMPTY;
                  end
               end
               default: begin
                  status_in = cpq_pkg::STAT_OK;
               end
            endcase
         end
         cpq_pkg::S_INS_START: begin
            if (idx_ff == '0) begin
               occ_in = occ_ff + CNT_W'(1);
            end
         end
         cpq_pkg::S_INS_WALK: begin
            if (shift_down) begin
               idx_in = idx_ff - IDX_W'(1);
            end else begin
               occ_in = occ_ff + CNT_W'(1);
            end
         end
         cpq_pkg::S_DEQ_HEAD: begin
            rtag_in  = rd_tag;
            rprio_in = rd_prio;
            idx_in   = '0;
            if (occ_ff == CNT_W'(1)) begin
               occ_in = '0;
            end
         end
         cpq_pkg::S_DEQ_WALK: begin
            if (deq_more) begin
               idx_in = idx_ff + IDX_W'(1);
            end else begin
               occ_in = occ_ff - CNT_W'(1);
            end
         end
         cpq_pkg::S_HEAD: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_rtag_in   = rtag_ext[OUT_W-1:0];
               rsp_rprio_in  = rprio_ff;
               rsp_hvalid_in = !empty;
               rsp_htag_in   = empty ? '0 : htag_ext[OUT_W-1:0];
               rsp_hprio_in  = empty ? '0 : rd_prio;
               rsp_fill_in   = occ_ff;
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase

      if (csr_write_enable && csr_index < cpq_pkg::CSR_IDX_W'(cpq_pkg::NUM_CAT)) begin
         counter_in[csr_index] = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpq_pkg::S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         counter_ff   <= cpq_pkg::BASE_RESET;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         counter_ff   <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      cat_ff        <= cat_in;
      eprio_ff      <= eprio_in;
      tag_ff        <= tag_in;
      prio_ff       <= prio_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rtag_ff       <= rtag_in;
      rprio_ff      <= rprio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rtag_ff   <= rsp_rtag_in;
      rsp_rprio_ff  <= rsp_rprio_in;
      rsp_hvalid_ff <= rsp_hvalid_in;
      rsp_htag_ff   <= rsp_htag_in;
      rsp_hprio_ff  <= rsp_hprio_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy exceeds depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while an item is in progress");

   a_head_matches_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hvalid_ff == (rsp_fill_ff != '0)))
      else $error("head valid disagrees with fill count");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CNT_W'(wr_addr) < CNT_W'(DEPTH)))
      else $error("RAM write beyond queue depth");
`endif

endmodule
